@@ sv/two_level_exclusive_cache_model_macros.svh @@
// assertion macros for the two-level exclusive cache model
`ifndef TWO_LEVEL_EXCLUSIVE_CACHE_MODEL_MACROS_SVH
`define TWO_LEVEL_EXCLUSIVE_CACHE_MODEL_MACROS_SVH
`ifndef SYNTHESIS
`define TLEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TLEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TLEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TLEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/tlec_pkg.sv @@
// package with types and constants of the two-level exclusive cache model
package tlec_pkg;
	localparam int L1_MAX_SETS = 64;
	localparam int L1_MAX_WAYS = 4;
	localparam int L2_MAX_SETS = 256;
	localparam int L2_MAX_WAYS = 8;
	localparam int L1_SET_W = 6;
	localparam int L2_SET_W = 8;
	localparam int L1_PTR_W = 2;
	localparam int L2_PTR_W = 3;
	localparam int ADDR_W = 32;

	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_RD_HIT  = 3'd1;
	localparam logic [2:0] ST_RD_MISS = 3'd2;
	localparam logic [2:0] ST_WR_HIT  = 3'd3;
	localparam logic [2:0] ST_WR_MISS = 3'd4;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam logic [2:0] CFG_L1_OFF  = 3'd0;
	localparam logic [2:0] CFG_L1_IDX  = 3'd1;
	localparam logic [2:0] CFG_L1_WAYS = 3'd2;
	localparam logic [2:0] CFG_L2_OFF  = 3'd3;
	localparam logic [2:0] CFG_L2_IDX  = 3'd4;
	localparam logic [2:0] CFG_L2_WAYS = 3'd5;

	typedef struct packed {
		logic        req_type;
		logic [31:0] address;
	} in_t;

	typedef struct packed {
		logic [2:0] l1_status;
		logic [2:0] l2_status;
	} out_t;
endpackage

@@ sv/two_level_exclusive_cache_model.sv @@
// top level: sequencer over the tag stores of both cache levels
// flow: set lookup, then an l1 scan that skips invalid ways and compares valid ones; a read hit ends
// there, a write hit rewrites the l1 line; a miss scans l2, where a write hit rewrites the l2 line
// a read miss saves a full set's l1 victim, fills l1, frees an l2 hit and moves the victim to l2
// throughput: one item at a time, a stalled result holds the sequencer until it is taken
// reset: asynchronous active low; a clearing pass then sweeps the valid and pointer stores
module two_level_exclusive_cache_model (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tlec_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tlec_pkg::out_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [3:0]     cfg_data
);
	import tlec_pkg::*;
	`include "two_level_exclusive_cache_model_macros.svh"

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_META   = 4'd2;
	localparam logic [3:0] S_META_W = 4'd3;
	localparam logic [3:0] S_L1_RD  = 4'd4;
	localparam logic [3:0] S_L1_CMP = 4'd5;
	localparam logic [3:0] S_EV_CAP = 4'd6;
	localparam logic [3:0] S_L2_RD  = 4'd7;
	localparam logic [3:0] S_L2_CMP = 4'd8;
	localparam logic [3:0] S_FILL1  = 4'd9;
	localparam logic [3:0] S_F2_RD  = 4'd10;
	localparam logic [3:0] S_F2_W   = 4'd11;
	localparam logic [3:0] S_F2     = 4'd12;
	localparam logic [3:0] S_DONE   = 4'd13;

	logic [3:0] state_q;
	logic [7:0] clr_cnt_q;
	logic [3:0] l1_off_q, l2_off_q, l2_idx_q, l2_ways_q;
	logic [2:0] l1_idx_q, l1_ways_q;

	logic                      req_q;
	logic [31:0]               addr_q, old_q;
	logic [L1_SET_W-1:0]       set1_q;
	logic [L2_SET_W-1:0]       set2_q;
	logic [L1_MAX_WAYS-1:0]    v1_q;
	logic [L1_PTR_W-1:0]       p1_q;
	logic [L2_MAX_WAYS-1:0]    v2_q;
	logic [L2_PTR_W-1:0]       p2_q;
	logic [3:0]                w_q;
	logic [L1_PTR_W-1:0]       hw1_q;
	logic [L2_PTR_W-1:0]       hw2_q;
	logic                      hit2_q, ev_q;
	logic [2:0]                s1_q, s2_q;
	logic                      out_valid_q;
	out_t                      out_q;

	logic [2:0] ways1;
	logic [3:0] ways2;
	logic [4:0] sh1, sh2;
	logic       match;
	logic [31:0] cmp_b;
	logic [4:0]  cmp_sh;

	logic                     m1_we;
	logic [L1_SET_W-1:0]      m1_waddr;
	logic [L1_PTR_W+L1_MAX_WAYS-1:0] m1_wdata, m1_rdata;
	logic                     m2_we;
	logic [L2_SET_W-1:0]      m2_waddr, m2_raddr;
	logic [L2_PTR_W+L2_MAX_WAYS-1:0] m2_wdata, m2_rdata;
	logic                     a1_we;
	logic [L1_SET_W+L1_PTR_W-1:0] a1_waddr, a1_raddr;
	logic [31:0]              a1_rdata;
	logic                     a2_we;
	logic [L2_SET_W+L2_PTR_W-1:0] a2_waddr, a2_raddr;
	logic [31:0]              a2_wdata, a2_rdata;

	logic                  fe1_found, fe2_found;
	logic [L1_PTR_W-1:0]   fe1, vic1, fill1_way, np1;
	logic [L2_PTR_W-1:0]   fe2, vic2, fill2_way, np2;
	logic [L1_MAX_WAYS-1:0] nv1;
	logic [L2_MAX_WAYS-1:0] nv2, v2_clr;

	function automatic logic [L1_SET_W-1:0] set1_of(logic [31:0] a, logic [3:0] off,
			logic [2:0] idxb);
		logic [31:0] s;
		logic [L1_SET_W-1:0] m;
		s = a >> off;
		for (int i = 0; i < L1_SET_W; i++) begin
			m[i] = (i < int'(idxb));
		end
		return s[L1_SET_W-1:0] & m;
	endfunction

	function automatic logic [L2_SET_W-1:0] set2_of(logic [31:0] a, logic [3:0] off,
			logic [3:0] idxb);
		logic [31:0] s;
		logic [L2_SET_W-1:0] m;
		s = a >> off;
		for (int i = 0; i < L2_SET_W; i++) begin
			m[i] = (i < int'(idxb));
		end
		return s[L2_SET_W-1:0] & m;
	endfunction

	assign ways1 = (l1_ways_q == 3'd0) ? 3'd1 :
		((l1_ways_q > 3'(L1_MAX_WAYS)) ? 3'(L1_MAX_WAYS) : l1_ways_q);
	assign ways2 = (l2_ways_q == 4'd0) ? 4'd1 :
		((l2_ways_q > 4'(L2_MAX_WAYS)) ? 4'(L2_MAX_WAYS) : l2_ways_q);
	assign sh1 = 5'(l1_off_q) + 5'(l1_idx_q);
	assign sh2 = 5'(l2_off_q) + 5'(l2_idx_q);

	assign cmp_b  = (state_q == S_L1_CMP) ? a1_rdata : a2_rdata;
	assign cmp_sh = (state_q == S_L1_CMP) ? sh1 : sh2;

	tlec_tag_cmp u_cmp (
		.a     (addr_q),
		.b     (cmp_b),
		.sh    (cmp_sh),
		.match (match)
	);

	// first empty way and victim per level
	always_comb begin
		fe1_found = 1'b0;
		fe1 = '0;
		for (int i = L1_MAX_WAYS - 1; i >= 0; i--) begin
			if (i < int'(ways1) && !v1_q[i]) begin
				fe1_found = 1'b1;
				fe1 = L1_PTR_W'(i);
			end
		end
		vic1 = (3'(p1_q) < ways1) ? p1_q : '0;
		fill1_way = fe1_found ? fe1 : vic1;
		nv1 = v1_q | (L1_MAX_WAYS'(1) << fill1_way);
		np1 = fe1_found ? p1_q :
			((3'(vic1) + 3'd1 == ways1) ? '0 : L1_PTR_W'(3'(vic1) + 3'd1));

		fe2_found = 1'b0;
		fe2 = '0;
		for (int i = L2_MAX_WAYS - 1; i >= 0; i--) begin
			if (i < int'(ways2) && !v2_q[i]) begin
				fe2_found = 1'b1;
				fe2 = L2_PTR_W'(i);
			end
		end
		vic2 = (4'(p2_q) < ways2) ? p2_q : '0;
		fill2_way = fe2_found ? fe2 : vic2;
		nv2 = v2_q | (L2_MAX_WAYS'(1) << fill2_way);
		np2 = fe2_found ? p2_q :
			((4'(vic2) + 4'd1 == ways2) ? '0 : L2_PTR_W'(4'(vic2) + 4'd1));
		v2_clr = v2_q & ~(L2_MAX_WAYS'(1) << hw2_q);
	end

	// store port control
	always_comb begin
		m1_we = 1'b0;
		m1_waddr = set1_q;
		m1_wdata = {p1_q, v1_q};
		m2_we = 1'b0;
		m2_waddr = set2_q;
		m2_wdata = {p2_q, v2_q};
		m2_raddr = set2_q;
		a1_we = 1'b0;
		a1_waddr = {set1_q, fill1_way};
		a1_raddr = {set1_q, w_q[L1_PTR_W-1:0]};
		a2_we = 1'b0;
		a2_waddr = {set2_q, hw2_q};
		a2_wdata = addr_q;
		a2_raddr = {set2_q, w_q[L2_PTR_W-1:0]};
		unique case (state_q)
			S_CLR: begin
				m1_we = 1'b1;
				m1_waddr = clr_cnt_q[L1_SET_W-1:0];
				m1_wdata = '0;
				m2_we = 1'b1;
				m2_waddr = clr_cnt_q;
				m2_wdata = '0;
			end
			S_L1_RD: begin
				if ((4'(ways1) <= w_q) && req_q == REQ_READ && !fe1_found) begin
					a1_raddr = {set1_q, vic1};
				end
			end
			S_L2_RD: begin
				if ((ways2 <= w_q) && req_q == REQ_WRITE && hit2_q) begin
					a2_we = 1'b1;
				end
			end
			S_FILL1: begin
				a1_we = 1'b1;
				if (s1_q == ST_WR_HIT) begin
					a1_waddr = {set1_q, hw1_q};
				end else begin
					m1_we = 1'b1;
					m1_wdata = {np1, nv1};
					if (hit2_q) begin
						m2_we = 1'b1;
						m2_wdata = {p2_q, v2_clr};
					end
				end
			end
			S_F2: begin
				a2_we = 1'b1;
				a2_waddr = {set2_q, fill2_way};
				a2_wdata = old_q;
				m2_we = 1'b1;
				m2_wdata = {np2, nv2};
			end
			default: begin
			end
		endcase
	end

	tlec_ram #(.WIDTH(L1_PTR_W + L1_MAX_WAYS), .DEPTH(L1_MAX_SETS)) u_meta1 (
		.clk(clk), .we(m1_we), .waddr(m1_waddr), .wdata(m1_wdata),
		.raddr(set1_q), .rdata(m1_rdata)
	);
	tlec_ram #(.WIDTH(L2_PTR_W + L2_MAX_WAYS), .DEPTH(L2_MAX_SETS)) u_meta2 (
		.clk(clk), .we(m2_we), .waddr(m2_waddr), .wdata(m2_wdata),
		.raddr(m2_raddr), .rdata(m2_rdata)
	);
	tlec_ram #(.WIDTH(ADDR_W), .DEPTH(L1_MAX_SETS * L1_MAX_WAYS)) u_addr1 (
		.clk(clk), .we(a1_we), .waddr(a1_waddr), .wdata(addr_q),
		.raddr(a1_raddr), .rdata(a1_rdata)
	);
	tlec_ram #(.WIDTH(ADDR_W), .DEPTH(L2_MAX_SETS * L2_MAX_WAYS)) u_addr2 (
		.clk(clk), .we(a2_we), .waddr(a2_waddr), .wdata(a2_wdata),
		.raddr(a2_raddr), .rdata(a2_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_off_q  <= 4'd5;
			l1_idx_q  <= 3'd6;
			l1_ways_q <= 3'd4;
			l2_off_q  <= 4'd5;
			l2_idx_q  <= 4'd8;
			l2_ways_q <= 4'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_L1_OFF:  l1_off_q  <= cfg_data;
				CFG_L1_IDX:  l1_idx_q  <= cfg_data[2:0];
				CFG_L1_WAYS: l1_ways_q <= cfg_data[2:0];
				CFG_L2_OFF:  l2_off_q  <= cfg_data;
				CFG_L2_IDX:  l2_idx_q  <= cfg_data;
				CFG_L2_WAYS: l2_ways_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + 8'd1;
					if (clr_cnt_q == 8'(L2_MAX_SETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q  <= in_data.req_type;
						addr_q <= in_data.address;
						set1_q <= set1_of(in_data.address, l1_off_q, l1_idx_q);
						set2_q <= set2_of(in_data.address, l2_off_q, l2_idx_q);
						state_q <= S_META;
					end
				end
				S_META: begin
					state_q <= S_META_W;
				end
				S_META_W: begin
					{p1_q, v1_q} <= m1_rdata;
					{p2_q, v2_q} <= m2_rdata;
					w_q <= '0;
					hit2_q <= 1'b0;
					ev_q <= 1'b0;
					state_q <= S_L1_RD;
				end
				S_L1_RD: begin
					if (4'(ways1) <= w_q) begin
						w_q <= '0;
						if (req_q == REQ_WRITE) begin
							s1_q <= ST_WR_MISS;
							state_q <= S_L2_RD;
						end else begin
							s1_q <= ST_RD_MISS;
							state_q <= fe1_found ? S_L2_RD : S_EV_CAP;
						end
					end else if (!v1_q[w_q[L1_PTR_W-1:0]]) begin
						w_q <= w_q + 4'd1;
					end else begin
						state_q <= S_L1_CMP;
					end
				end
				S_L1_CMP: begin
					if (match) begin
						hw1_q <= w_q[L1_PTR_W-1:0];
						s2_q <= ST_NONE;
						s1_q <= (req_q == REQ_WRITE) ? ST_WR_HIT : ST_RD_HIT;
						state_q <= (req_q == REQ_WRITE) ? S_FILL1 : S_DONE;
					end else begin
						w_q <= w_q + 4'd1;
						state_q <= S_L1_RD;
					end
				end
				S_EV_CAP: begin
					old_q <= a1_rdata;
					ev_q <= 1'b1;
					state_q <= S_L2_RD;
				end
				S_L2_RD: begin
					if (ways2 <= w_q) begin
						if (req_q == REQ_WRITE) begin
							s2_q <= hit2_q ? ST_WR_HIT : ST_WR_MISS;
							state_q <= S_DONE;
						end else begin
							s2_q <= hit2_q ? ST_RD_HIT : ST_RD_MISS;
							state_q <= S_FILL1;
						end
					end else if (hit2_q || !v2_q[w_q[L2_PTR_W-1:0]]) begin
						w_q <= w_q + 4'd1;
					end else begin
						state_q <= S_L2_CMP;
					end
				end
				S_L2_CMP: begin
					if (match) begin
						hit2_q <= 1'b1;
						hw2_q <= w_q[L2_PTR_W-1:0];
					end
					w_q <= w_q + 4'd1;
					state_q <= S_L2_RD;
				end
				S_FILL1: begin
					if (s1_q == ST_WR_HIT) begin
						state_q <= S_DONE;
					end else begin
						if (hit2_q) begin
							v2_q <= v2_clr;
						end
						set2_q <= set2_of(old_q, l2_off_q, l2_idx_q);
						state_q <= ev_q ? S_F2_RD : S_DONE;
					end
				end
				S_F2_RD: begin
					state_q <= S_F2_W;
				end
				S_F2_W: begin
					{p2_q, v2_q} <= m2_rdata;
					state_q <= S_F2;
				end
				S_F2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.l1_status <= s1_q;
						out_q.l2_status <= s2_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`TLEC_ASSERT_IMP(a_l2_none_on_hit, clk, arst_n, out_valid_q && (out_q.l1_status == ST_RD_HIT || out_q.l1_status == ST_WR_HIT), out_q.l2_status == ST_NONE)
	`TLEC_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`TLEC_ASSERT_IMP(a_way_bound, clk, arst_n, state_q == S_L1_CMP, w_q < 4'(ways1))
endmodule

@@ sv/tlec_ram.sv @@
// generic single write port ram with registered read
module tlec_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/tlec_tag_cmp.sv @@
// shared tag compare unit: drops the address bits below a shift and compares the rest
module tlec_tag_cmp (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [4:0]  sh,
	output logic        match
);
	logic [31:0] diff;

	assign diff  = (a ^ b) >> sh;
	assign match = (diff == 32'd0);
endmodule

@@ verif/tb.sv @@
// testbench for the two-level exclusive cache model with a built-in predictor
`timescale 1ns / 100ps

module tb;
	import tlec_pkg::*;

	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 172;

	typedef struct {
		logic       req;
		logic [31:0] addr;
		bit         typed;
		out_t       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	// cache state of the predictor, level 0 is l1 and level 1 is l2
	bit          line_vld [2][2048];
	logic [31:0] line_adr [2][2048];
	int unsigned vict_ptr [2][256];
	int unsigned geo_off [2];
	int unsigned geo_idx [2];
	int unsigned geo_ways [2];
	int unsigned max_sets [2] = '{L1_MAX_SETS, L2_MAX_SETS};
	int unsigned max_ways [2] = '{L1_MAX_WAYS, L2_MAX_WAYS};

	out_t status_q [$];
	bit cur_typed = 0;
	out_t cur_want = '0;
	int errors = 0;
	int checked = 0;
	int rd_hits = 0;
	int wr_hits = 0;
	bit calm = 0;
	logic [31:0] pool [16];

	two_level_exclusive_cache_model dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int unsigned ways_in_use(int l);
		if (geo_ways[l] == 0) return 1;
		if (geo_ways[l] > max_ways[l]) return max_ways[l];
		return geo_ways[l];
	endfunction

	function automatic int unsigned set_of(int l, logic [31:0] a);
		logic [31:0] s;
		logic [31:0] m;
		s = a >> geo_off[l];
		m = (32'd1 << geo_idx[l]) - 32'd1;
		return (s & m) % max_sets[l];
	endfunction

	function automatic int lookup(int l, logic [31:0] a);
		int unsigned sh;
		int unsigned slot;
		sh = geo_off[l] + geo_idx[l];
		for (int w = 0; w < ways_in_use(l); w++) begin
			slot = set_of(l, a) * max_ways[l] + w;
			if (line_vld[l][slot] && (sh >= 32 || (line_adr[l][slot] >> sh) == (a >> sh)))
				return slot;
		end
		return -1;
	endfunction

	function automatic int unsigned victim(int l, int unsigned s);
		return (vict_ptr[l][s] < ways_in_use(l)) ? vict_ptr[l][s] : 0;
	endfunction

	function automatic bit set_full(int l, logic [31:0] a);
		for (int w = 0; w < ways_in_use(l); w++)
			if (!line_vld[l][set_of(l, a) * max_ways[l] + w]) return 0;
		return 1;
	endfunction

	function automatic void fill(int l, logic [31:0] a);
		int unsigned s;
		int unsigned w;
		s = set_of(l, a);
		for (int i = 0; i < ways_in_use(l); i++) begin
			if (!line_vld[l][s * max_ways[l] + i]) begin
				line_vld[l][s * max_ways[l] + i] = 1;
				line_adr[l][s * max_ways[l] + i] = a;
				return;
			end
		end
		w = victim(l, s);
		line_adr[l][s * max_ways[l] + w] = a;
		vict_ptr[l][s] = (w + 1) % ways_in_use(l);
	endfunction

	function automatic out_t access(in_t it);
		out_t r;
		int h1;
		int h2;
		bit ev;
		logic [31:0] old;
		h1 = lookup(0, it.address);
		old = '0;
		if (h1 >= 0) begin
			r.l1_status = (it.req_type == REQ_WRITE) ? ST_WR_HIT : ST_RD_HIT;
			r.l2_status = ST_NONE;
			if (it.req_type == REQ_WRITE) line_adr[0][h1] = it.address;
		end else if (it.req_type == REQ_READ) begin
			ev = set_full(0, it.address);
			if (ev) old = line_adr[0][set_of(0, it.address) * max_ways[0]
				+ victim(0, set_of(0, it.address))];
			r.l1_status = ST_RD_MISS;
			h2 = lookup(1, it.address);
			fill(0, it.address);
			if (h2 >= 0) begin
				r.l2_status = ST_RD_HIT;
				line_vld[1][h2] = 0;
			end else begin
				r.l2_status = ST_RD_MISS;
			end
			if (ev) fill(1, old);
		end else begin
			r.l1_status = ST_WR_MISS;
			h2 = lookup(1, it.address);
			if (h2 >= 0) begin
				r.l2_status = ST_WR_HIT;
				line_adr[1][h2] = it.address;
			end else begin
				r.l2_status = ST_WR_MISS;
			end
		end
		return r;
	endfunction

	task automatic report(string what, logic [2:0] got, logic [2:0] want);
		errors++;
		$display("mismatch %s: got %0d want %0d", what, got, want);
	endtask

	function automatic int unsigned gap_len();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// acceptance and checking
	always @(posedge clk) begin
		out_t want;
		if (in_valid && in_ready) begin
			want = access(in_data);
			status_q.insert(status_q.size(), cur_typed ? cur_want : want);
		end
		if (out_valid && out_ready) begin
			if (status_q.size() == 0) begin
				report("unexpected item l1_status", out_data.l1_status, ST_NONE);
			end else begin
				want = status_q.pop_front();
				checked++;
				if (want.l1_status == ST_RD_HIT || want.l2_status == ST_RD_HIT) rd_hits++;
				if (want.l1_status == ST_WR_HIT || want.l2_status == ST_WR_HIT) wr_hits++;
				if (out_data.l1_status !== want.l1_status)
					report("l1_status", out_data.l1_status, want.l1_status);
				if (out_data.l2_status !== want.l2_status)
					report("l2_status", out_data.l2_status, want.l2_status);
			end
		end
	end

	// receiver stalls
	initial begin
		int unsigned stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = gap_len();
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [3:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_L1_OFF:  geo_off[0] = val;
			CFG_L1_IDX:  geo_idx[0] = val & 4'h7;
			CFG_L1_WAYS: geo_ways[0] = val & 4'h7;
			CFG_L2_OFF:  geo_off[1] = val;
			CFG_L2_IDX:  geo_idx[1] = val;
			CFG_L2_WAYS: geo_ways[1] = val;
			default: ;
		endcase
	endtask

	task automatic send(logic req, logic [31:0] a, bit typed, out_t want);
		int unsigned g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= '{req_type: req, address: a};
		cur_typed = typed;
		cur_want = want;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_addr();
		int unsigned r;
		logic [31:0] a;
		r = $urandom_range(0, 99);
		a = pool[$urandom_range(0, 15)];
		if (r < 20) return $urandom();
		if (r < 30) return a ^ (32'd1 << $urandom_range(0, 31));
		if (r < 60) return a ^ $urandom_range(0, 63);
		return a;
	endfunction

	initial begin
		row_t dir [$];
		logic [3:0] setting [6];
		geo_off = '{5, 5};
		geo_idx = '{6, 8};
		geo_ways = '{4, 8};
		foreach (line_vld[l, i]) line_vld[l][i] = 0;
		foreach (line_adr[l, i]) line_adr[l][i] = '0;
		foreach (vict_ptr[l, i]) vict_ptr[l][i] = 0;
		dir = '{
			'{REQ_READ,  32'h0000_0000, 1, '{ST_RD_MISS, ST_RD_MISS}},
			'{REQ_READ,  32'h0000_001f, 1, '{ST_RD_HIT,  ST_NONE}},
			'{REQ_WRITE, 32'h0000_0004, 1, '{ST_WR_HIT,  ST_NONE}},
			'{REQ_WRITE, 32'hffff_ffff, 1, '{ST_WR_MISS, ST_WR_MISS}},
			'{REQ_READ,  32'hffff_ffff, 1, '{ST_RD_MISS, ST_RD_MISS}},
			'{REQ_READ,  32'hffff_ffe0, 1, '{ST_RD_HIT,  ST_NONE}},
			'{REQ_READ,  32'h0000_0800, 0, '{ST_NONE, ST_NONE}},
			'{REQ_READ,  32'h0000_1000, 0, '{ST_NONE, ST_NONE}},
			'{REQ_READ,  32'h0000_1800, 0, '{ST_NONE, ST_NONE}},
			'{REQ_READ,  32'h0000_2000, 0, '{ST_NONE, ST_NONE}},
			'{REQ_READ,  32'h0000_0000, 0, '{ST_NONE, ST_NONE}},
			'{REQ_WRITE, 32'h0000_0000, 0, '{ST_NONE, ST_NONE}},
			'{REQ_READ,  32'h0000_2800, 0, '{ST_NONE, ST_NONE}},
			'{REQ_WRITE, 32'h0000_0800, 0, '{ST_NONE, ST_NONE}},
			'{REQ_READ,  32'h0000_0800, 0, '{ST_NONE, ST_NONE}},
			'{REQ_READ,  32'h8000_0000, 0, '{ST_NONE, ST_NONE}},
			'{REQ_WRITE, 32'h5555_5555, 0, '{ST_NONE, ST_NONE}},
			'{REQ_WRITE, 32'haaaa_aaaa, 0, '{ST_NONE, ST_NONE}}
		};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		calm = 1;
		foreach (dir[i]) send(dir[i].req, dir[i].addr, dir[i].typed, dir[i].want);
		drain();
		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) setting = '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
			else if (p == 1) setting = '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15};
			else if (p == 2) setting = '{4'd12, 4'd1, 4'd4, 4'd3, 4'd2, 4'd8};
			else if (p == 3) setting = '{4'd4, 4'd2, 4'd2, 4'd6, 4'd1, 4'd2};
			else foreach (setting[i]) setting[i] = 4'($urandom_range(0, 15));
			for (int r = 0; r < 6; r++) cfg_write(r[2:0], setting[r]);
			@(negedge clk);
			cfg_valid <= 1'b0;
			foreach (pool[i]) pool[i] = $urandom();
			calm = (p % 3 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2 && p == 2) drain();
				send(($urandom_range(0, 99) < 35) ? REQ_WRITE : REQ_READ, pick_addr(),
					0, '{ST_NONE, ST_NONE});
			end
			drain();
		end
		$display("accesses checked: %0d over %0d geometries, read hits %0d, write hits %0d",
			checked, PHASES + 1, rd_hits, wr_hits);
		if (errors == 0 && status_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d items still expected", errors, status_q.size());
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout");
		$display("status: fail");
		$finish;
	end
endmodule
